// ===== design/dns_name_skip_macros.svh =====
// ----------------------------------------------------------------------------
// DNS name skip assertion macros
// Shared concurrent assertion helpers for the name skip block.
// ----------------------------------------------------------------------------
`ifndef DNS_NAME_SKIP_MACROS_SVH
`define DNS_NAME_SKIP_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define DNSSKIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DNSSKIP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/dnsskip_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS name skip package
// Shared widths, status codes and the result type of the name skip block.
// ----------------------------------------------------------------------------
package dnsskip_pkg;

  localparam int unsigned LenW  = 16;
  localparam int unsigned StatW = 2;

  // Largest number of bytes one name may consume before an overrun.
  localparam logic [LenW-1:0] MaxBufferBytes = 16'd65535;

  localparam logic [StatW-1:0] StOk       = 2'd0;
  localparam logic [StatW-1:0] StBadLabel = 2'd1;
  localparam logic [StatW-1:0] StOverrun  = 2'd2;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [LenW-1:0]  name_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] byte_value;
    logic       end_of_buffer;
  } in_item_t;

endpackage

// ===== design/dnsskip_in_stage.sv =====
// ----------------------------------------------------------------------------
// DNS name skip input stage
// Registers one incoming byte transfer; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module dnsskip_in_stage import dnsskip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       take_i,
  output in_item_t   item_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
  end

  assign item_o = '{valid: valid_q, byte_value: byte_q, end_of_buffer: last_q};

endmodule

// ===== design/dnsskip_walk.sv =====
// ----------------------------------------------------------------------------
// DNS name skip label walker
// Holds the label parse state and decides the result for each byte.
// ----------------------------------------------------------------------------
module dnsskip_walk import dnsskip_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     out_free_i,
  output logic     take_o,
  output logic     emit_o,
  output result_t  result_o
);

  `include "dns_name_skip_macros.svh"

  localparam logic [2:0] PhLen  = 3'd0;
  localparam logic [2:0] PhSkip = 3'd1;
  localparam logic [2:0] PhPtr  = 3'd2;
  localparam logic [2:0] PhBits = 3'd3;

  logic [2:0]      phase_q, phase_d;
  logic [5:0]      skip_q, skip_d;
  logic [LenW-1:0] count_q, count_d;
  logic            given_q, given_d;

  logic [7:0]      b;
  logic [8:0]      bits;
  logic [9:0]      bits_round;
  logic            emit;
  result_t         res;

  assign take_o = item_i.valid && out_free_i;
  assign b      = item_i.byte_value;

  // A zero bit count stands for 256 bits.
  assign bits       = (b == 8'd0) ? 9'd256 : {1'b0, b};
  assign bits_round = {1'b0, bits} + 10'd7;

  always_comb begin
    phase_d = phase_q;
    skip_d  = skip_q;
    count_d = count_q;
    given_d = given_q;
    emit    = 1'b0;
    res     = '{status: StOk, name_length: '0};
    if (take_o) begin
      if (!given_q) begin
        if (count_q >= MaxBufferBytes) begin
          emit    = 1'b1;
          given_d = 1'b1;
          res     = '{status: StOverrun, name_length: '0};
        end else begin
          count_d = count_q + 16'd1;
          case (phase_q)
            PhSkip: begin
              skip_d = skip_q - 6'd1;
              if (skip_d == 6'd0) begin
                phase_d = PhLen;
              end
            end
            PhPtr: begin
              emit    = 1'b1;
              given_d = 1'b1;
              res     = '{status: StOk, name_length: count_d};
            end
            PhBits: begin
              skip_d  = bits_round[8:3];
              phase_d = PhSkip;
            end
            default: begin
              if (b == 8'd0) begin
                emit    = 1'b1;
                given_d = 1'b1;
                res     = '{status: StOk, name_length: count_d};
              end else if (b[7:6] == 2'b00) begin
                skip_d  = b[5:0];
                phase_d = PhSkip;
              end else if (b[7:6] == 2'b11) begin
                phase_d = PhPtr;
              end else if (b == 8'h41) begin
                phase_d = PhBits;
              end else begin
                emit    = 1'b1;
                given_d = 1'b1;
                res     = '{status: StBadLabel, name_length: '0};
              end
            end
          endcase
          // The buffer ran out before the name was closed.
          if (item_i.end_of_buffer && !given_d) begin
            emit    = 1'b1;
            given_d = 1'b1;
            if (phase_d == PhSkip || phase_d == PhPtr || phase_d == PhBits) begin
              res = '{status: StOverrun, name_length: '0};
            end else begin
              res = '{status: StOk, name_length: count_d};
            end
          end
        end
      end
      if (item_i.end_of_buffer) begin
        phase_d = PhLen;
        skip_d  = 6'd0;
        count_d = '0;
        given_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLen;
      skip_q  <= 6'd0;
      count_q <= '0;
      given_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      count_q <= count_d;
      given_q <= given_d;
    end
  end

  assign emit_o   = emit;
  assign result_o = res;

  `DNSSKIP_ASSERT_RST(a_reset_state, !rst_ni |-> (phase_q == PhLen && !given_q), "state not cleared in reset")
  `DNSSKIP_ASSERT(a_one_result, (take_o && given_q) |-> !emit, "second result for one buffer")
  `DNSSKIP_ASSERT(a_skip_nonzero, (phase_q == PhSkip) |-> (skip_q != 6'd0), "skip phase with empty count")
  `DNSSKIP_ASSERT(a_buffer_restart, (take_o && item_i.end_of_buffer) |=> (phase_q == PhLen && count_q == '0 && !given_q), "state not restarted after buffer end")
  `DNSSKIP_ASSERT(a_error_zero_len, (emit && res.status != StOk) |-> (res.name_length == '0), "error result with nonzero length")

endmodule

// ===== design/dnsskip_out_stage.sv =====
// ----------------------------------------------------------------------------
// DNS name skip output stage
// Result register toward the downstream stream.
// ----------------------------------------------------------------------------
module dnsskip_out_stage import dnsskip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        emit_i,
  input  result_t     result_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (emit_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      res_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {6'd0, res_q.status, res_q.name_length};

endmodule

// ===== design/dns_name_skip.sv =====
// ----------------------------------------------------------------------------
// DNS name skip
// Finds the end of the encoded domain name at the start of each buffer.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata                      tlast
// s_axis   in         [7:0] byte_value           end_of_buffer
// m_axis   out        [15:0] name_length,        unused
//                     [17:16] status
//
// One byte transfer per cycle: input register, label walker, result register.
// Each byte passes the input register and the walker; its result is held in the result register.
// Reset clears the parse state and both stage valids; no clearing pass.
// A stalled result holds the walker; bytes keep flowing while the result
// register is empty or being drained.
// ----------------------------------------------------------------------------
module dns_name_skip import dnsskip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] name_length, [17:16] status, zero fill
);

  in_item_t item;
  logic     take;
  logic     emit;
  logic     out_free;
  result_t  result;

  dnsskip_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .item_o        (item)
  );

  dnsskip_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .emit_o     (emit),
    .result_o   (result)
  );

  dnsskip_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .emit_i        (emit),
    .result_i      (result),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== verif/dns_name_skip_tb.sv =====
// ----------------------------------------------------------------------------
// DNS name skip testbench
// Streams DNS message buffers into the name skip block, predicts the length or
// error of each leading encoded name and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_name_skip_tb;
  import dnsskip_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned RandomItems = 1550;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned IdlePercent = 36;

  localparam logic [7:0] NameEnd        = 8'h00;
  localparam logic [7:0] LabelBitString = 8'h41;
  localparam logic [1:0] PointerMark    = 2'b11;
  localparam logic [1:0] PlainMark      = 2'b00;

  typedef enum logic [2:0] {
    WalkLength  = 3'd0,
    WalkSkip    = 3'd1,
    WalkPointer = 3'd2,
    WalkBits    = 3'd3
  } walk_phase_e;

  // Tracks one buffer at a time and queues the result that each byte causes.
  class name_length_board;
    walk_phase_e phase;
    logic [5:0]  skip_left;
    logic [15:0] consumed;
    bit          answered;
    result_t     awaited[$];
    int unsigned errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      phase     = WalkLength;
      skip_left = '0;
      consumed  = '0;
      answered  = 1'b0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void walk_byte(logic [7:0] b, bit last);
      result_t r;
      bit      got;
      int      bits;
      got = 1'b0;
      r   = '0;
      if (!answered) begin
        if (consumed >= MaxBufferBytes) begin
          r.status = StOverrun;
          got = 1'b1;
        end else begin
          consumed = consumed + 16'd1;
          case (phase)
            WalkSkip: begin
              skip_left = skip_left - 6'd1;
              if (skip_left == 6'd0) phase = WalkLength;
            end
            WalkPointer: begin
              r.status = StOk;
              r.name_length = consumed;
              got = 1'b1;
            end
            WalkBits: begin
              bits = (b == 8'd0) ? 256 : int'(b);
              skip_left = 6'((bits + 7) / 8);
              phase = WalkSkip;
            end
            default: begin
              if (b == NameEnd) begin
                r.status = StOk;
                r.name_length = consumed;
                got = 1'b1;
              end else if (b[7:6] == PlainMark) begin
                skip_left = b[5:0];
                phase = WalkSkip;
              end else if (b[7:6] == PointerMark) begin
                phase = WalkPointer;
              end else if (b == LabelBitString) begin
                phase = WalkBits;
              end else begin
                r.status = StBadLabel;
                got = 1'b1;
              end
            end
          endcase
          if (last && !got) begin
            got = 1'b1;
            if (phase != WalkLength) begin
              r.status = StOverrun;
            end else begin
              r.status = StOk;
              r.name_length = consumed;
            end
          end
        end
      end
      if (got) begin
        awaited.push_back(r);
        answered = 1'b1;
      end
      if (last) restart();
    endfunction

    function void check_result(logic [23:0] data);
      result_t want;
      result_t seen;
      seen = result_t'(data[17:0]);
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d length %0d",
                 $time, seen.status, seen.name_length);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (seen.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, seen.status);
        errors++;
      end
      if (seen.name_length != want.name_length) begin
        $display("%0t: name_length expected %0d actual %0d",
                 $time, want.name_length, seen.name_length);
        errors++;
      end
      if (data[23:18] != '0) begin
        $display("%0t: tdata fill expected 0 actual %0h", $time, data[23:18]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] byte_value
  logic        s_axis_tlast  = 1'b0; // end_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [15:0] name_length, [17:16] status, zero fill

  bit               burst = 1'b0;
  int unsigned      cycles = 0;
  logic [7:0]       buf_bytes[$];
  name_length_board sb;

  dns_name_skip u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= burst || ($urandom_range(99) >= IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    @(negedge clk_i);
    while (!burst && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.walk_byte(b, last);
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
  endtask

  // Drops valid so the last transfer is not repeated, then waits for results.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic void push_random(int unsigned count);
    repeat (count) buf_bytes.push_back(8'($urandom));
  endfunction

  // Mostly well-formed names with random content; the rest is raw noise,
  // truncated names and trailing bytes after the name.
  function automatic void build_random_buffer();
    int unsigned len;
    int unsigned bits;
    int unsigned keep;
    buf_bytes.delete();
    if ($urandom_range(99) < 25) begin
      push_random($urandom_range(6, 1));
      return;
    end
    repeat ($urandom_range(4)) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(9))
          0:       bits = 0;
          1, 2:    bits = $urandom_range(255);
          default: bits = $urandom_range(64, 1);
        endcase
        buf_bytes.push_back(LabelBitString);
        buf_bytes.push_back(8'(bits));
        push_random((bits == 0) ? 32 : (bits + 7) / 8);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(63, 1) : $urandom_range(8, 1);
        buf_bytes.push_back(8'(len));
        push_random(len);
      end
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4: buf_bytes.push_back(NameEnd);
      5, 6, 7: begin
        buf_bytes.push_back({PointerMark, 6'($urandom)});
        push_random(1);
      end
      default: ;
    endcase
    if (buf_bytes.size() == 0) buf_bytes.push_back(NameEnd);
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(buf_bytes.size(), 1);
      while (buf_bytes.size() > keep) void'(buf_bytes.pop_back());
    end
    if ($urandom_range(99) < 30) push_random($urandom_range(3, 1));
  endfunction

  initial begin
    int unsigned sent;
    sb = new();
    // Reset falls just after time zero so the asynchronous reset sees an edge.
    #1;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    buf_bytes = '{8'h00};                      send_buffer();
    buf_bytes = '{8'h01, 8'h61, 8'h00};        send_buffer();
    buf_bytes = '{8'hC0, 8'hFF};               send_buffer();
    buf_bytes = '{8'hFF, 8'h00};               send_buffer();
    buf_bytes = '{8'h40};                      send_buffer();
    buf_bytes = '{8'hBF, 8'h12};               send_buffer();
    buf_bytes = '{8'h41, 8'h09, 8'hAA, 8'h55, 8'h00}; send_buffer();
    buf_bytes = '{8'h02, 8'h7E, 8'h81};        send_buffer();
    buf_bytes = '{8'h03, 8'h61};               send_buffer();
    buf_bytes = '{8'hC5};                      send_buffer();
    buf_bytes = '{8'h41};                      send_buffer();
    // The sender holds off until every result so far has come back.
    wait_drained();
    repeat ($urandom_range(20, 5)) @(negedge clk_i);

    sent = 0;
    while (sent < RandomItems) begin
      burst = (sent >= 600 && sent < 900);
      build_random_buffer();
      send_buffer();
      sent += buf_bytes.size();
    end
    burst = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
